### design/rc_serial_frame_to_stick_state_unit_macros.svh
// Assertion macros for the serial frame to stick state unit.
// Uses the clk and arst_n names of the module that includes it.
`ifndef RC_SERIAL_FRAME_TO_STICK_STATE_UNIT_MACROS_SVH
`define RC_SERIAL_FRAME_TO_STICK_STATE_UNIT_MACROS_SVH

// same-cycle implication
`define RCFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RCFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/rcfs_pkg.sv
// Shared types and constants of the serial frame to stick state unit.
// No dependencies.
`timescale 1ns / 1ps
package rcfs_pkg;

	localparam int CH_COUNT = 5;
	localparam int CH_W = 16;
	localparam int D_W = 10;
	localparam int MAG_W = 25;
	localparam int RECIP_W = 26;
	localparam int PROD_W = MAG_W + RECIP_W;
	localparam int DIV_SHIFT = 35;
	localparam int CFG_IDX_W = 1;

	localparam logic [7:0] HDR0 = 8'h20;
	localparam logic [7:0] HDR1 = 8'h40;
	localparam logic [15:0] CHK_BASE = 16'hFFFF;
	localparam logic [15:0] CH_LO = 16'd1000;
	localparam logic [15:0] CH_HI = 16'd2000;
	localparam logic [15:0] ARM_LEVEL = 16'd1500;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 26'd34359739;
	localparam logic signed [16:0] THR_COEF = 17'sd25600;
	localparam logic signed [25:0] AXIS_SCALE = 26'sd1000;
	localparam logic signed [15:0] AXIS_MIN_RST = -16'sd5120;
	localparam logic signed [15:0] AXIS_MAX_RST = 16'sd5120;
	localparam logic [CH_COUNT-1:0][CH_W-1:0] CH_RST =
		{16'd1000, 16'd1500, 16'd1000, 16'd1500, 16'd1500};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_MIN = 1'b0,
		REG_AXIS_MAX = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic seen;
		logic now;
		logic [CH_COUNT-1:0][CH_W-1:0] ch;
	} win_t;

	typedef struct packed {
		logic seen;
		logic now;
		logic armed;
	} flags_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} lane_en_t;

	function automatic logic [D_W-1:0] clamp_offset(input logic [CH_W-1:0] ch);
		logic [CH_W-1:0] v;
		v = ch;
		if (v < CH_LO) v = CH_LO;
		if (v > CH_HI) v = CH_HI;
		return D_W'(v - CH_LO);
	endfunction

endpackage

### design/rcfs_ifs.sv
// Channel interfaces: received byte stream, stick state results, config writes.
// Depends on rcfs_pkg.
`timescale 1ns / 1ps
interface rcfs_byte_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcfs_stick_if;
	logic valid;
	logic ready;
	logic frame_seen;
	logic frame_now;
	logic armed;
	logic signed [15:0] roll;
	logic signed [15:0] pitch;
	logic signed [15:0] yaw;
	logic [14:0] throttle;
	modport source (output valid, output frame_seen, output frame_now, output armed,
		output roll, output pitch, output yaw, output throttle, input ready);
	modport sink (input valid, input frame_seen, input frame_now, input armed,
		input roll, input pitch, input yaw, input throttle, output ready);
endinterface

interface rcfs_cfg_if;
	logic valid;
	logic ready;
	logic [rcfs_pkg::CFG_IDX_W-1:0] index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### design/rc_serial_frame_to_stick_state_unit.sv
// Takes one byte per cycle while stick.ready does not stall the output stages.
// Stages: frame check and channel latch, clamp and multiply, offset, reciprocal
// multiply for the divide by 1000, sign restore and gating into the output register.
// Reset clears the byte window and checksum, loads channel defaults, clears frame_seen
// and sets the axis range to -5120..5120 in Q7.8. Config writes always accepted.
`timescale 1ns / 1ps
`include "rc_serial_frame_to_stick_state_unit_macros.svh"
module rc_serial_frame_to_stick_state_unit #(
	parameter int PACKET_BYTES = 32
) (
	input logic clk,
	input logic arst_n,
	rcfs_byte_if.sink rx,
	rcfs_stick_if.source stick,
	rcfs_cfg_if.sink cfg
);
	logic signed [15:0] axis_min_q;
	logic signed [15:0] axis_max_q;
	logic signed [16:0] span;
	logic signed [25:0] min_k;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic take;
	rcfs_pkg::lane_en_t en;
	rcfs_pkg::win_t win_s1;
	rcfs_pkg::flags_t flg_s2, flg_s3, flg_s4, flg_s5;
	logic signed [15:0] roll_s5, pitch_s5, yaw_s5, thr_s5;
	logic sticks_zero;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_min_q <= rcfs_pkg::AXIS_MIN_RST;
			axis_max_q <= rcfs_pkg::AXIS_MAX_RST;
		end else if (cfg.valid) begin
			case (rcfs_pkg::cfg_reg_t'(cfg.index))
				rcfs_pkg::REG_AXIS_MIN: axis_min_q <= signed'(cfg.data);
				rcfs_pkg::REG_AXIS_MAX: axis_max_q <= signed'(cfg.data);
				default: ;
			endcase
		end
	end

	always_comb begin
		span = 17'(axis_max_q) - 17'(axis_min_q);
		min_k = 26'(axis_min_q) * rcfs_pkg::AXIS_SCALE;
	end

	always_comb begin
		rdy5 = !vld_s5 || stick.ready;
		rdy4 = !vld_s4 || rdy5;
		rdy3 = !vld_s3 || rdy4;
		rdy2 = !vld_s2 || rdy3;
		rdy1 = !vld_s1 || rdy2;
		take = rx.valid && rdy1;
		en.s2 = vld_s1 && rdy2;
		en.s3 = vld_s2 && rdy3;
		en.s4 = vld_s3 && rdy4;
		en.s5 = vld_s4 && rdy5;
	end

	assign rx.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= take || (vld_s1 && !rdy2);
			vld_s2 <= en.s2 || (vld_s2 && !rdy3);
			vld_s3 <= en.s3 || (vld_s3 && !rdy4);
			vld_s4 <= en.s4 || (vld_s4 && !rdy5);
			vld_s5 <= en.s5 || (vld_s5 && !stick.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			flg_s2.seen <= win_s1.seen;
			flg_s2.now <= win_s1.now;
			flg_s2.armed <= win_s1.seen && (win_s1.ch[4] > rcfs_pkg::ARM_LEVEL);
		end
		if (en.s3) begin
			flg_s3 <= flg_s2;
		end
		if (en.s4) begin
			flg_s4 <= flg_s3;
		end
		if (en.s5) begin
			flg_s5 <= flg_s4;
		end
	end

	rcfs_window #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.rx_byte(rx.rx_byte),
		.win_s1(win_s1)
	);

	rcfs_lane u_roll (
		.clk(clk), .en(en), .ch_s1(win_s1.ch[0]), .coef(span), .offset(min_k),
		.keep_s4(flg_s4.armed), .res_s5(roll_s5)
	);

	rcfs_lane u_pitch (
		.clk(clk), .en(en), .ch_s1(win_s1.ch[1]), .coef(span), .offset(min_k),
		.keep_s4(flg_s4.armed), .res_s5(pitch_s5)
	);

	rcfs_lane u_yaw (
		.clk(clk), .en(en), .ch_s1(win_s1.ch[3]), .coef(span), .offset(min_k),
		.keep_s4(flg_s4.armed), .res_s5(yaw_s5)
	);

	rcfs_lane u_throttle (
		.clk(clk), .en(en), .ch_s1(win_s1.ch[2]), .coef(rcfs_pkg::THR_COEF),
		.offset(26'sd0), .keep_s4(flg_s4.armed), .res_s5(thr_s5)
	);

	assign stick.valid = vld_s5;
	assign stick.frame_seen = flg_s5.seen;
	assign stick.frame_now = flg_s5.now;
	assign stick.armed = flg_s5.armed;
	assign stick.roll = roll_s5;
	assign stick.pitch = pitch_s5;
	assign stick.yaw = yaw_s5;
	assign stick.throttle = thr_s5[14:0];

	assign sticks_zero = (stick.roll == '0) && (stick.pitch == '0) && (stick.yaw == '0) &&
		(stick.throttle == '0);

	`RCFS_ASSERT_NOW(a_now_seen, stick.valid && stick.frame_now, stick.frame_seen, "frame_now without frame_seen")
	`RCFS_ASSERT_NOW(a_arm_seen, stick.valid && stick.armed, stick.frame_seen, "armed without frame_seen")
	`RCFS_ASSERT_NOW(a_idle_zero, stick.valid && !stick.armed, sticks_zero, "sticks not zero while disarmed")
	`RCFS_ASSERT_NOW(a_thr_max, stick.valid, stick.throttle <= 15'd25600, "throttle above full scale")
	`RCFS_ASSERT_NEXT(a_s1_hold, vld_s1 && !rdy2, vld_s1 && $stable(win_s1), "first stage lost or changed while stalled")
endmodule

### design/rcfs_window.sv
// Byte window with running checksum, frame detect and channel latch.
// Depends on rcfs_pkg.
`timescale 1ns / 1ps
module rcfs_window #(
	parameter int PACKET_BYTES = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  logic [7:0] rx_byte,
	output rcfs_pkg::win_t win_s1
);
	localparam int SUM_SPAN = PACKET_BYTES - 2;
	localparam int LAST = PACKET_BYTES - 1;

	logic [PACKET_BYTES-1:0][7:0] win_q;
	logic [15:0] sum_q;
	logic [15:0] sum_d;
	logic [15:0] rx_chk;
	logic [rcfs_pkg::CH_COUNT-1:0][rcfs_pkg::CH_W-1:0] ch_q;
	logic [rcfs_pkg::CH_COUNT-1:0][rcfs_pkg::CH_W-1:0] ch_new;
	logic [rcfs_pkg::CH_COUNT-1:0][rcfs_pkg::CH_W-1:0] ch_d;
	logic seen_q;
	logic hit;

	always_comb begin
		sum_d = sum_q - 16'(win_q[0]) + 16'(win_q[SUM_SPAN]);
		rx_chk = {rx_byte, win_q[LAST]};
		hit = (win_q[1] == rcfs_pkg::HDR0) && (win_q[2] == rcfs_pkg::HDR1) &&
			((rcfs_pkg::CHK_BASE - sum_d) == rx_chk);
		for (int i = 0; i < rcfs_pkg::CH_COUNT; i++) begin
			ch_new[i] = {win_q[4 + 2 * i], win_q[3 + 2 * i]};
		end
		ch_d = hit ? ch_new : ch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			sum_q <= '0;
			ch_q <= rcfs_pkg::CH_RST;
			seen_q <= 1'b0;
		end else if (take) begin
			win_q <= {rx_byte, win_q[LAST:1]};
			sum_q <= sum_d;
			ch_q <= ch_d;
			seen_q <= seen_q | hit;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			win_s1.seen <= seen_q | hit;
			win_s1.now <= hit;
			win_s1.ch <= ch_d;
		end
	end
endmodule

### design/rcfs_lane.sv
// One mapping lane: clamp, scale, offset, divide by 1000 toward zero, gate.
// Depends on rcfs_pkg.
`timescale 1ns / 1ps
module rcfs_lane (
	input  logic clk,
	input  rcfs_pkg::lane_en_t en,
	input  logic [rcfs_pkg::CH_W-1:0] ch_s1,
	input  logic signed [16:0] coef,
	input  logic signed [25:0] offset,
	input  logic keep_s4,
	output logic signed [15:0] res_s5
);
	logic [rcfs_pkg::D_W-1:0] d;
	logic signed [rcfs_pkg::D_W:0] ds;
	logic signed [27:0] prod_s2;
	logic signed [27:0] num;
	logic neg_s3;
	logic [rcfs_pkg::MAG_W-1:0] mag_s3;
	logic neg_s4;
	logic [rcfs_pkg::PROD_W-1:0] prod_s4;
	logic [15:0] q;
	logic [15:0] qs;

	always_comb begin
		d = rcfs_pkg::clamp_offset(ch_s1);
		ds = signed'({1'b0, d});
		num = prod_s2 + 28'(offset);
		q = prod_s4[rcfs_pkg::DIV_SHIFT +: 16];
		qs = neg_s4 ? (~q + 16'd1) : q;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= ds * coef;
		end
		if (en.s3) begin
			neg_s3 <= num[27];
			mag_s3 <= num[27] ? rcfs_pkg::MAG_W'(-num) : rcfs_pkg::MAG_W'(num);
		end
		if (en.s4) begin
			neg_s4 <= neg_s3;
			prod_s4 <= rcfs_pkg::PROD_W'(mag_s3) * rcfs_pkg::PROD_W'(rcfs_pkg::DIV_RECIP);
		end
		if (en.s5) begin
			res_s5 <= keep_s4 ? signed'(qs) : '0;
		end
	end
endmodule
